// ----- hdl/tmc_pkg.sv -----
// Shared types, field widths, codes and defaults for the text console engine.
// No dependencies; every other file of the block imports this package.
package tmc_pkg;

    localparam int DEF_COLUMNS   = 80;
    localparam int DEF_ROWS      = 25;
    localparam int DEF_TAB_WIDTH = 8;

    localparam int CMD_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 4;
    localparam int INDEX_W = 11;
    localparam int LOC_W   = 11;
    localparam int CELL_W  = 16;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_PRINT,
        OP_BS,
        OP_TAB,
        OP_CR,
        OP_LF,
        OP_CLEAR,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [CHAR_W-1:0]    char_code;
        logic [2*COLOR_W-1:0] attr;
        logic [INDEX_W-1:0]   cell_index;
    } item_t;

endpackage

// ----- hdl/tmc_if.sv -----
// Valid/ready channel interfaces for the command and result streams.
// Depends on tmc_pkg for the field widths.
interface tmc_cmd_if;
    import tmc_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [CHAR_W-1:0]  char_code;
    logic [COLOR_W-1:0] back_color;
    logic [COLOR_W-1:0] fore_color;
    logic [INDEX_W-1:0] cell_index;

    modport source (
        output valid, command, char_code, back_color, fore_color, cell_index,
        input  ready
    );
    modport sink (
        input  valid, command, char_code, back_color, fore_color, cell_index,
        output ready
    );
endinterface

interface tmc_res_if;
    import tmc_pkg::*;

    logic              valid;
    logic              ready;
    logic [LOC_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] cell_data;
    logic              did_scroll;

    modport source (
        output valid, cursor_pos, cell_data, did_scroll,
        input  ready
    );
    modport sink (
        input  valid, cursor_pos, cell_data, did_scroll,
        output ready
    );
endinterface

// ----- hdl/tmc_front.sv -----
// Front end: takes command transactions, decodes them into operations and
// holds them in a two-entry queue for the back end. Depends on tmc_pkg, tmc_if.
module tmc_front (
    input  logic          clk,
    input  logic          rst_n,
    tmc_cmd_if.sink       cmd,
    output tmc_pkg::item_t item,
    output logic          item_valid,
    input  logic          item_pop
);
    import tmc_pkg::*;

    localparam int QDEPTH = 2;

    item_t      q_reg [QDEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    item_t      entry;

    function automatic op_t classify(logic [CMD_W-1:0] command, logic [CHAR_W-1:0] ch);
        op_t op;
        op = OP_NOP;
        case (command)
            CMD_PUT:
            begin
                if (ch == CH_BS)
                    op = OP_BS;
                else if (ch == CH_TAB)
                    op = OP_TAB;
                else if (ch == CH_CR)
                    op = OP_CR;
                else if (ch == CH_LF)
                    op = OP_LF;
                else if (ch inside {[CH_PRINT_LO:CH_PRINT_HI]})
                    op = OP_PRINT;
            end
            CMD_CLEAR: op = OP_CLEAR;
            CMD_READ:  op = OP_READ;
            default:   op = OP_NOP;
        endcase
        return op;
    endfunction

    assign cmd.ready  = (count_reg != 2'(QDEPTH));
    assign push       = cmd.valid && cmd.ready;
    assign item       = q_reg[rd_ptr_reg];
    assign item_valid = (count_reg != 2'd0);

    always_comb
    begin
        entry.op         = classify(cmd.command, cmd.char_code);
        entry.char_code  = cmd.char_code;
        entry.attr       = {cmd.back_color, cmd.fore_color};
        entry.cell_index = cmd.cell_index;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (item_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({push, item_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- hdl/tmc_back.sv -----
// Back end: cursor logic, screen store with its clear/scroll sweeps, and
// the result register. Depends on tmc_pkg and tmc_if.
module tmc_back #(
    parameter int COLUMNS   = tmc_pkg::DEF_COLUMNS,
    parameter int ROWS      = tmc_pkg::DEF_ROWS,
    parameter int TAB_WIDTH = tmc_pkg::DEF_TAB_WIDTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  tmc_pkg::item_t item,
    input  logic           item_valid,
    output logic           item_pop,
    tmc_res_if.source      res
);
    import tmc_pkg::*;

    localparam int CELLS     = ROWS * COLUMNS;
    localparam int AW        = $clog2(CELLS);
    localparam int LW        = ((AW > LOC_W) ? AW : LOC_W) + 1;
    localparam int CLW       = $clog2(COLUMNS);
    localparam int CTW       = $clog2(COLUMNS + TAB_WIDTH + 1);
    localparam int PW        = $clog2(TAB_WIDTH);
    localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_FILL  = 3'd4;

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              we;

    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic [CLW-1:0]    col_reg, col_next;
    logic [PW-1:0]     phase_reg, phase_next;
    logic [AW-1:0]     base_reg, base_next;
    logic              pend_reg, pend_next;
    logic              in_range_reg, in_range_next;
    logic              res_valid_reg, res_valid_next;
    logic [LOC_W-1:0]  res_loc_reg, res_loc_next;
    logic [CELL_W-1:0] res_data_reg, res_data_next;
    logic              res_scroll_reg, res_scroll_next;

    logic              out_free;
    logic [CTW-1:0]    col_w;
    logic [PW-1:0]     phase_w;
    logic              row_inc;
    logic              scroll;
    logic [AW-1:0]     base_w;
    logic [CLW-1:0]    col_w_n;
    logic [LW-1:0]     new_loc;
    logic [LW-1:0]     cur_loc;
    logic [LW-1:0]     idx_l;

    assign out_free = !res_valid_reg || res.ready;
    assign cur_loc  = LW'(base_reg) + LW'(col_reg);
    assign idx_l    = LW'(item.cell_index);

    // cursor movement for put operations
    always_comb
    begin
        col_w   = CTW'(col_reg);
        phase_w = phase_reg;
        row_inc = 1'b0;
        case (item.op)
            OP_PRINT:
            begin
                col_w   = col_w + CTW'(1);
                phase_w = (phase_reg == PW'(TAB_WIDTH - 1)) ? '0 : phase_reg + PW'(1);
            end
            OP_BS:
            begin
                if (col_reg != '0)
                begin
                    col_w   = col_w - CTW'(1);
                    phase_w = (phase_reg == '0) ? PW'(TAB_WIDTH - 1) : phase_reg - PW'(1);
                end
            end
            OP_TAB:
            begin
                col_w   = col_w + CTW'(TAB_WIDTH) - CTW'(phase_reg);
                phase_w = '0;
            end
            OP_CR:
            begin
                col_w   = '0;
                phase_w = '0;
            end
            OP_LF:
            begin
                col_w   = '0;
                phase_w = '0;
                row_inc = 1'b1;
            end
            default: ;
        endcase
        if (col_w >= CTW'(COLUMNS))
        begin
            col_w   = '0;
            phase_w = '0;
            row_inc = 1'b1;
        end
        scroll  = row_inc && (base_reg == AW'(LAST_BASE));
        base_w  = (row_inc && !scroll) ? base_reg + AW'(COLUMNS) : base_reg;
        col_w_n = col_w[CLW-1:0];
        new_loc = LW'(base_w) + LW'(col_w_n);
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        col_next        = col_reg;
        phase_next      = phase_reg;
        base_next       = base_reg;
        pend_next       = pend_reg;
        in_range_next   = in_range_reg;
        res_valid_next  = res_valid_reg && !res.ready;
        res_loc_next    = res_loc_reg;
        res_data_next   = res_data_reg;
        res_scroll_next = res_scroll_reg;
        item_pop        = 1'b0;
        we              = 1'b0;
        wr_addr         = cnt_reg;
        wr_data         = BLANK_CELL;
        rd_addr         = cnt_reg + AW'(COLUMNS);

        case (state_reg)
            ST_CLEAR:
            begin
                we = 1'b1;
                if (cnt_reg == AW'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                    pend_next  = 1'b0;
                    if (pend_reg)
                    begin
                        res_valid_next  = 1'b1;
                        res_loc_next    = cur_loc[LOC_W-1:0];
                        res_data_next   = '0;
                        res_scroll_next = 1'b0;
                    end
                end
                else
                    cnt_next = cnt_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (item_valid && out_free)
                begin
                    item_pop = 1'b1;
                    case (item.op)
                        OP_CLEAR:
                        begin
                            col_next   = '0;
                            phase_next = '0;
                            base_next  = '0;
                            cnt_next   = '0;
                            pend_next  = 1'b1;
                            state_next = ST_CLEAR;
                        end
                        OP_READ:
                        begin
                            rd_addr       = idx_l[AW-1:0];
                            in_range_next = (idx_l < LW'(CELLS));
                            state_next    = ST_READ;
                        end
                        default:
                        begin
                            if (item.op == OP_PRINT)
                            begin
                                we      = 1'b1;
                                wr_addr = base_reg + AW'(col_reg);
                                wr_data = {item.attr, item.char_code};
                            end
                            col_next   = col_w_n;
                            phase_next = phase_w;
                            base_next  = base_w;
                            if (scroll)
                            begin
                                cnt_next   = '0;
                                state_next = ST_SHIFT;
                            end
                            else
                            begin
                                res_valid_next  = 1'b1;
                                res_loc_next    = new_loc[LOC_W-1:0];
                                res_data_next   = '0;
                                res_scroll_next = 1'b0;
                            end
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_valid_next  = 1'b1;
                res_loc_next    = cur_loc[LOC_W-1:0];
                res_data_next   = in_range_reg ? rd_data_reg : '0;
                res_scroll_next = 1'b0;
                state_next      = ST_IDLE;
            end
            ST_SHIFT:
            begin
                // read one row ahead, write the cell read on the previous cycle
                if (cnt_reg != '0)
                begin
                    we      = 1'b1;
                    wr_addr = cnt_reg - AW'(1);
                    wr_data = rd_data_reg;
                end
                if (cnt_reg == AW'(LAST_BASE))
                    state_next = ST_FILL;
                else
                    cnt_next = cnt_reg + AW'(1);
            end
            ST_FILL:
            begin
                we = 1'b1;
                if (cnt_reg == AW'(CELLS - 1))
                begin
                    cnt_next        = '0;
                    state_next      = ST_IDLE;
                    res_valid_next  = 1'b1;
                    res_loc_next    = cur_loc[LOC_W-1:0];
                    res_data_next   = '0;
                    res_scroll_next = 1'b1;
                end
                else
                    cnt_next = cnt_reg + AW'(1);
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        in_range_reg   <= in_range_next;
        res_loc_reg    <= res_loc_next;
        res_data_reg   <= res_data_next;
        res_scroll_reg <= res_scroll_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            col_reg       <= '0;
            phase_reg     <= '0;
            base_reg      <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            col_reg       <= col_next;
            phase_reg     <= phase_next;
            base_reg      <= base_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.cursor_pos = res_loc_reg;
    assign res.cell_data  = res_data_reg;
    assign res.did_scroll = res_scroll_reg;

endmodule

// ----- hdl/text_mode_console_engine.sv -----
// Top level of the character-cell text console: front end queue plus back end.
// Depends on tmc_pkg, tmc_if, tmc_front and tmc_back.
//
//   port  dir  contents
//   cmd   in   command, char_code, back_color, fore_color, cell_index
//   res   out  cursor_pos, cell_data, did_scroll
//
// Put (stored or control byte) and unused commands: done in the idle state.
// Read: adds the read state, for the registered read port of the screen store.
// Clear: a sweep over every cell; scroll: a row-shift sweep, then a last-row fill;
// both bound by the single write port of the screen store.
// After reset a clearing pass runs; up to two commands queue meanwhile.
// A stalled result holds the back end; the front queue takes commands until full.
module text_mode_console_engine #(
    parameter int COLUMNS   = tmc_pkg::DEF_COLUMNS,
    parameter int ROWS      = tmc_pkg::DEF_ROWS,
    parameter int TAB_WIDTH = tmc_pkg::DEF_TAB_WIDTH
) (
    input  logic      clk,
    input  logic      rst_n,
    tmc_cmd_if.sink   cmd,
    tmc_res_if.source res
);
    import tmc_pkg::*;

    item_t q_item;
    logic  q_valid;
    logic  q_pop;

    tmc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .item       (q_item),
        .item_valid (q_valid),
        .item_pop   (q_pop)
    );

    tmc_back #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (q_item),
        .item_valid (q_valid),
        .item_pop   (q_pop),
        .res        (res)
    );

endmodule

// ----- hdl/tmc_checker.sv -----
// Port-level assertions on the result stream of the console, with the bind
// that attaches them to text_mode_console_engine. Depends on tmc_pkg.
module tmc_checker #(
    parameter int COLUMNS = tmc_pkg::DEF_COLUMNS,
    parameter int ROWS    = tmc_pkg::DEF_ROWS
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       res_valid,
    input logic                       res_ready,
    input logic [tmc_pkg::LOC_W-1:0]  res_cursor_pos,
    input logic [tmc_pkg::CELL_W-1:0] res_cell_data,
    input logic                       res_did_scroll
);
    import tmc_pkg::*;

    localparam int CELLS     = ROWS * COLUMNS;
    localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_cursor_pos)
            && $stable(res_cell_data) && $stable(res_did_scroll))
        else $error("result changed while stalled");

    a_scroll_home: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_did_scroll |->
            res_cursor_pos == LOC_W'(LAST_BASE) && res_cell_data == '0)
        else $error("scroll result not at start of last row");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (CELLS > 2047) || (int'(res_cursor_pos) < CELLS))
        else $error("cursor location outside screen");

endmodule

bind text_mode_console_engine tmc_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tmc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_cursor_pos (res.cursor_pos),
    .res_cell_data  (res.cell_data),
    .res_did_scroll (res.did_scroll)
);

// ----- tb/tb_text_mode_console_engine.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for text_mode_console_engine: a directed command table, then
// random text, line-feed, read, noise and clear sequences scored against a screen predictor.
// Depends on tmc_pkg, the tmc_cmd_if / tmc_res_if interfaces and the engine RTL.
module tb_text_mode_console_engine;
    import tmc_pkg::*;

    localparam int SCR_COLS  = DEF_COLUMNS;
    localparam int SCR_ROWS  = DEF_ROWS;
    localparam int SCR_TAB   = DEF_TAB_WIDTH;
    localparam int SCR_CELLS = SCR_ROWS * SCR_COLS;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int     RANDOM_ITEMS = 850;
    localparam int     MAX_GAP      = 16;
    localparam int     MAX_SHOWN    = 10;
    localparam int     DRAIN_CYCLES = 2100;
    localparam longint CYCLE_LIMIT  = 64'd8_000_000;

    typedef struct {
        logic [CMD_W-1:0]   command;
        logic [CHAR_W-1:0]  char_code;
        logic [COLOR_W-1:0] back_color;
        logic [COLOR_W-1:0] fore_color;
        logic [INDEX_W-1:0] cell_index;
    } console_cmd_t;

    typedef struct {
        logic [LOC_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] cell_data;
        logic              did_scroll;
    } console_res_t;

    typedef struct {
        console_cmd_t c;
        int           reps;
        bit           typed;
        console_res_t want;
    } table_row_t;

    logic clk;
    logic rst_n;

    tmc_cmd_if cmd_ch();
    tmc_res_if res_ch();

    text_mode_console_engine u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    logic [CELL_W-1:0] screen_shadow [SCR_CELLS];
    int                cur_col;
    int                cur_row;

    console_res_t expected_results[$];
    table_row_t   dir_rows[$];
    console_res_t no_result;

    int     error_count;
    int     shown_count;
    int     items_sent;
    longint cycle_count;
    bit     src_idle_on;
    bit     sink_idle_on;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void blank_screen();
        for (int i = 0; i < SCR_CELLS; i++)
            screen_shadow[i] = BLANK_CELL;
        cur_col = 0;
        cur_row = 0;
    endfunction

    function automatic console_res_t predict_console(console_cmd_t c);
        console_res_t r;
        int           at;
        r.cell_data  = '0;
        r.did_scroll = 1'b0;
        case (c.command)
            CMD_PUT:
            begin
                if (c.char_code == CH_BS)
                begin
                    if (cur_col > 0)
                        cur_col--;
                end
                else if (c.char_code == CH_TAB)
                    cur_col = cur_col + SCR_TAB - (cur_col % SCR_TAB);
                else if (c.char_code == CH_CR)
                    cur_col = 0;
                else if (c.char_code == CH_LF)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                else if (c.char_code >= CH_PRINT_LO && c.char_code <= CH_PRINT_HI)
                begin
                    at = cur_row * SCR_COLS + cur_col;
                    if (at < SCR_CELLS)
                        screen_shadow[at] = {c.back_color, c.fore_color, c.char_code};
                    cur_col++;
                end
                if (cur_col >= SCR_COLS)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= SCR_ROWS)
                begin
                    for (int i = 0; i < SCR_CELLS - SCR_COLS; i++)
                        screen_shadow[i] = screen_shadow[i + SCR_COLS];
                    for (int i = SCR_CELLS - SCR_COLS; i < SCR_CELLS; i++)
                        screen_shadow[i] = BLANK_CELL;
                    cur_row      = SCR_ROWS - 1;
                    r.did_scroll = 1'b1;
                end
            end
            CMD_CLEAR:
                blank_screen();
            CMD_READ:
            begin
                if (int'(c.cell_index) < SCR_CELLS)
                    r.cell_data = screen_shadow[c.cell_index];
            end
            default: ;
        endcase
        r.cursor_pos = LOC_W'(cur_row * SCR_COLS + cur_col);
        return r;
    endfunction

    function automatic console_cmd_t make_cmd(logic [CMD_W-1:0] command, int ch, int back,
                                              int fore, int index);
        console_cmd_t c;
        c.command    = command;
        c.char_code  = CHAR_W'(ch);
        c.back_color = COLOR_W'(back);
        c.fore_color = COLOR_W'(fore);
        c.cell_index = INDEX_W'(index);
        return c;
    endfunction

    function automatic void add_row(console_cmd_t c, int reps, bit typed, int loc, int data,
                                    bit scrolled);
        table_row_t row;
        row.c               = c;
        row.reps            = reps;
        row.typed           = typed;
        row.want.cursor_pos = LOC_W'(loc);
        row.want.cell_data  = CELL_W'(data);
        row.want.did_scroll = scrolled;
        dir_rows.push_back(row);
    endfunction

    function automatic void note_error(string msg);
        error_count++;
        if (shown_count < MAX_SHOWN)
        begin
            shown_count++;
            $display("[%0t] %s", $realtime, msg);
        end
    endfunction

    task automatic send_command(console_cmd_t c, bit typed, console_res_t want);
        int           gap;
        console_res_t predicted;
        if (items_sent % 64 == 0)
            src_idle_on = ($urandom_range(0, 3) != 0);
        gap = src_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.command    = c.command;
        cmd_ch.char_code  = c.char_code;
        cmd_ch.back_color = c.back_color;
        cmd_ch.fore_color = c.fore_color;
        cmd_ch.cell_index = c.cell_index;
        cmd_ch.valid      = 1'b1;
        do @(posedge clk); while (cmd_ch.ready !== 1'b1);
        predicted = predict_console(c);
        expected_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic put_char(int ch);
        send_command(make_cmd(CMD_PUT, ch, $urandom_range(0, 15), $urandom_range(0, 15),
                              $urandom_range(0, 2047)), 1'b0, no_result);
    endtask

    // result side: random back-pressure, compare each transaction with the oldest prediction
    initial
    begin
        int           stall;
        int           taken;
        console_res_t want;
        res_ch.ready = 1'b0;
        taken        = 0;
        sink_idle_on = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (taken % 48 == 0)
                sink_idle_on = ($urandom_range(0, 3) != 0);
            stall = sink_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0)
            begin
                res_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready = 1'b1;
            do @(posedge clk); while (res_ch.valid !== 1'b1);
            taken++;
            if (expected_results.size() == 0)
                note_error($sformatf("unexpected transaction: loc=%0d data=%h scroll=%b",
                                     res_ch.cursor_pos, res_ch.cell_data,
                                     res_ch.did_scroll));
            else
            begin
                want = expected_results.pop_front();
                if (res_ch.cursor_pos !== want.cursor_pos ||
                    res_ch.cell_data !== want.cell_data ||
                    res_ch.did_scroll !== want.did_scroll)
                    note_error($sformatf(
                        {"mismatch #%0d: loc exp %0d got %0d, ",
                         "data exp %h got %h, scroll exp %b got %b"},
                        taken, want.cursor_pos, res_ch.cursor_pos, want.cell_data,
                        res_ch.cell_data, want.did_scroll, res_ch.did_scroll));
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int kind;
        int len;
        int pick;
        int lin;
        int idx;
        int cmd_pick;

        cmd_ch.valid      = 1'b0;
        cmd_ch.command    = CMD_PUT;
        cmd_ch.char_code  = '0;
        cmd_ch.back_color = '0;
        cmd_ch.fore_color = '0;
        cmd_ch.cell_index = '0;
        rst_n             = 1'b0;
        error_count       = 0;
        shown_count       = 0;
        items_sent        = 0;
        src_idle_on       = 1'b1;
        no_result         = '{cursor_pos: '0, cell_data: '0, did_scroll: 1'b0};
        blank_screen();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_row(make_cmd(CMD_READ,  0,           0,  0, 0),    1, 1'b1, 0, BLANK_CELL, 1'b0);
        add_row(make_cmd(CMD_READ,  0,           0,  0, 1999), 1, 1'b1, 0, BLANK_CELL, 1'b0);
        add_row(make_cmd(CMD_READ,  0,           0,  0, 2047), 1, 1'b1, 0, 0,          1'b0);
        add_row(make_cmd(CMD_PUT,   8'h41,       15, 15, 0),   1, 1'b1, 1, 0,          1'b0);
        add_row(make_cmd(CMD_PUT,   CH_PRINT_LO, 0,  0, 2047), 1, 1'b1, 2, 0,          1'b0);
        add_row(make_cmd(CMD_PUT,   CH_PRINT_HI, 10, 5, 0),    1, 1'b1, 3, 0,          1'b0);
        add_row(make_cmd(CMD_READ,  0,           0,  0, 0),    1, 1'b1, 3, 16'hFF41,   1'b0);
        add_row(make_cmd(CMD_READ,  0,           0,  0, 2),    1, 1'b1, 3, 16'hA57F,   1'b0);
        add_row(make_cmd(CMD_PUT,   8'h80,       15, 15, 0),   1, 1'b1, 3, 0,          1'b0);
        add_row(make_cmd(CMD_PUT,   8'hFF,       15, 15, 0),   1, 1'b1, 3, 0,          1'b0);
        add_row(make_cmd(CMD_PUT,   8'h00,       0,  0, 0),    1, 1'b1, 3, 0,          1'b0);
        add_row(make_cmd(CMD_PUT,   8'h1F,       0,  0, 0),    1, 1'b1, 3, 0,          1'b0);
        add_row(make_cmd(CMD_PUT,   CH_BS,       0,  0, 0),    1, 1'b1, 2, 0,          1'b0);
        add_row(make_cmd(CMD_PUT,   CH_TAB,      0,  0, 0),    1, 1'b1, 8, 0,          1'b0);
        add_row(make_cmd(CMD_PUT,   CH_CR,       0,  0, 0),    1, 1'b1, 0, 0,          1'b0);
        add_row(make_cmd(CMD_PUT,   CH_BS,       0,  0, 0),    1, 1'b1, 0, 0,          1'b0);
        add_row(make_cmd(CMD_PUT,   CH_LF,       0,  0, 0),    1, 1'b1, 80, 0,         1'b0);
        add_row(make_cmd(CMD_UNUSED, 8'h41,      15, 15, 2047), 1, 1'b1, 80, 0,        1'b0);
        // tabs across a whole row, the last one wraps into the next row
        add_row(make_cmd(CMD_PUT,   CH_TAB,      0,  0, 0),    10, 1'b0, 0, 0,         1'b0);
        add_row(make_cmd(CMD_READ,  0,           0,  0, 160),  1, 1'b0, 0, 0,          1'b0);
        add_row(make_cmd(CMD_CLEAR, 8'hFF,       15, 15, 2047), 1, 1'b1, 0, 0,         1'b0);
        add_row(make_cmd(CMD_READ,  0,           0,  0, 0),    1, 1'b1, 0, BLANK_CELL, 1'b0);

        foreach (dir_rows[i])
            for (int k = 0; k < dir_rows[i].reps; k++)
                send_command(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                // a line of text with occasional tabs and backspaces
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100)
                                                  : $urandom_range(1, 30);
                for (int k = 0; k < len; k++)
                begin
                    pick = $urandom_range(0, 19);
                    if (pick == 0)
                        put_char(CH_TAB);
                    else if (pick == 1)
                        put_char(CH_BS);
                    else
                        put_char($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
                end
                pick = $urandom_range(0, 9);
                if (pick < 5)
                begin
                    put_char(CH_CR);
                    put_char(CH_LF);
                end
                else if (pick < 8)
                    put_char(CH_LF);
            end
            else if (kind < 55)
            begin
                len = $urandom_range(1, 8);
                repeat (len) put_char(CH_LF);
            end
            else if (kind < 75)
            begin
                len = $urandom_range(1, 4);
                repeat (len)
                begin
                    if ($urandom_range(0, 2) != 0)
                    begin
                        lin = cur_row * SCR_COLS + cur_col;
                        idx = lin - $urandom_range(0, 160);
                        if (idx < 0)
                            idx = 0;
                    end
                    else
                        idx = $urandom_range(0, 2047);
                    send_command(make_cmd(CMD_READ, $urandom_range(0, 255),
                                          $urandom_range(0, 15), $urandom_range(0, 15), idx),
                                 1'b0, no_result);
                end
            end
            else if (kind < 98)
            begin
                len = $urandom_range(1, 4);
                repeat (len)
                begin
                    cmd_pick = $urandom_range(0, 5);
                    send_command(make_cmd((cmd_pick < 4) ? CMD_PUT
                                          : (cmd_pick == 4) ? CMD_READ : CMD_UNUSED,
                                          $urandom_range(0, 255), $urandom_range(0, 15),
                                          $urandom_range(0, 15), $urandom_range(0, 2047)),
                                 1'b0, no_result);
                end
            end
            else
                send_command(make_cmd(CMD_CLEAR, $urandom_range(0, 255), $urandom_range(0, 15),
                                      $urandom_range(0, 15), $urandom_range(0, 2047)),
                             1'b0, no_result);
        end

        @(negedge clk);
        cmd_ch.valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
